@@ rtl/assert_macros.svh @@
// assertion helpers used by the rdc_checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be seen on a clock edge outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ rtl/rdc_pkg.sv @@
package rdc_pkg;

    localparam int NUMBER_W   = 31;
    localparam int DIGIT_W    = 4;
    localparam int RADIX_W    = 4;
    localparam int CHUNK_W    = 8;
    localparam int WORK_W     = 32;
    localparam int CHUNKS     = WORK_W / CHUNK_W;
    localparam int CHUNK_CNT_W = $clog2(CHUNKS);

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 4'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 4'd9;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 4'd2;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_TEST = 5'b00010,
        S_DIV  = 5'b00100,
        S_READ = 5'b01000,
        S_LOAD = 5'b10000
    } state_t;

    typedef struct packed {
        logic start;
        logic div_step;
        logic push;
        logic pop_rd;
        logic out_load;
        logic cfg_write;
    } cmd_t;

    typedef struct packed {
        logic work_zero;
        logic stack_empty;
        logic rd_last;
        logic out_free;
    } status_t;

    typedef struct packed {
        logic [DIGIT_W-1:0] rem;
        logic [CHUNK_W-1:0] quo;
    } step_t;

    // eight restoring division steps by a small base, msb first
    function automatic step_t div_chunk(input logic [DIGIT_W-1:0] rem_in,
                                        input logic [CHUNK_W-1:0] bits,
                                        input logic [RADIX_W-1:0] base);
        logic [DIGIT_W:0]   r;
        logic [CHUNK_W-1:0] q;
        step_t              res;
        r = {1'b0, rem_in};
        q = '0;
        for (int i = CHUNK_W - 1; i >= 0; i--)
        begin
            r = {r[DIGIT_W-1:0], bits[i]};
            if (r >= {1'b0, base})
            begin
                r    = r - {1'b0, base};
                q[i] = 1'b1;
            end
        end
        res.rem = r[DIGIT_W-1:0];
        res.quo = q;
        return res;
    endfunction

endpackage

@@ rtl/rdc_ctrl.sv @@
module rdc_ctrl
    import rdc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    cfg_valid,
    input  status_t status,
    output logic    in_stall,
    output logic    cfg_ready,
    output cmd_t    cmd
);

    state_t                 state_reg, state_next;
    logic [CHUNK_CNT_W-1:0] chunk_reg, chunk_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            chunk_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            chunk_reg <= chunk_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        chunk_next    = chunk_reg;
        cmd           = '0;
        cmd.cfg_write = cfg_valid && (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_TEST;
                end
            end
            S_TEST:
            begin
                chunk_next = '0;
                if (!status.work_zero)
                    state_next = S_DIV;
                else if (status.stack_empty)
                    state_next = S_IDLE;
                else
                    state_next = S_READ;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (chunk_reg == CHUNK_CNT_W'(CHUNKS - 1))
                begin
                    // remainder of this pass is final, onto the stack
                    cmd.push   = 1'b1;
                    state_next = S_TEST;
                end
                else
                begin
                    chunk_next = chunk_reg + CHUNK_CNT_W'(1);
                end
            end
            S_READ:
            begin
                cmd.pop_rd = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = status.rd_last ? S_IDLE : S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/rdc_datapath.sv @@
module rdc_datapath
    import rdc_pkg::*;
#(
    parameter int STACK_DEPTH = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    input  logic [NUMBER_W-1:0] number,
    input  logic [RADIX_W-1:0]  radix,
    input  logic                out_stall,
    output status_t             status,
    output logic                out_valid,
    output logic [DIGIT_W-1:0]  digit,
    output logic                last_digit
);

    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);

    logic [DIGIT_W-1:0] stack_mem [STACK_DEPTH];

    logic [WORK_W-1:0]  work_reg, work_next;
    logic [DIGIT_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [RADIX_W-1:0] base_reg, base_next;
    logic               out_valid_reg, out_valid_next;
    logic [DIGIT_W-1:0] digit_reg;
    logic               last_reg;
    logic [DIGIT_W-1:0] rd_data_reg;
    logic               rd_last_reg;

    step_t              step;
    logic               stack_full;
    logic [CNT_W-1:0]   count_m1;

    assign step       = div_chunk(rem_reg, work_reg[WORK_W-1 -: CHUNK_W], base_reg);
    assign stack_full = (count_reg >= CNT_W'(STACK_DEPTH));
    assign count_m1   = count_reg - CNT_W'(1);

    always_comb
    begin
        base_next = base_reg;
        if (cmd.cfg_write)
        begin
            if (radix < RADIX_MIN)
                base_next = RADIX_MIN;
            else if (radix > RADIX_MAX)
                base_next = RADIX_MAX;
            else
                base_next = radix;
        end
    end

    always_comb
    begin
        work_next  = work_reg;
        rem_next   = rem_reg;
        count_next = count_reg;
        if (cmd.start)
        begin
            work_next  = {1'b0, number};
            rem_next   = '0;
            count_next = '0;
        end
        else if (cmd.div_step)
        begin
            work_next = {work_reg[WORK_W-CHUNK_W-1:0], step.quo};
            rem_next  = cmd.push ? '0 : step.rem;
            if (cmd.push && !stack_full)
                count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.pop_rd)
        begin
            count_next = count_m1;
        end
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            base_reg      <= RADIX_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            base_reg      <= base_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
        if (cmd.out_load)
        begin
            digit_reg <= rd_data_reg;
            last_reg  <= rd_last_reg;
        end
    end

    // digit stack, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.div_step && cmd.push && !stack_full)
            stack_mem[count_reg[ADDR_W-1:0]] <= step.rem;
        if (cmd.pop_rd)
        begin
            rd_data_reg <= stack_mem[count_m1[ADDR_W-1:0]];
            rd_last_reg <= (count_m1 == '0);
        end
    end

    assign status.work_zero   = (work_reg == '0);
    assign status.stack_empty = (count_reg == '0);
    assign status.rd_last     = rd_last_reg;
    assign status.out_free    = !out_valid_reg || !out_stall;

    assign out_valid  = out_valid_reg;
    assign digit      = digit_reg;
    assign last_digit = last_reg;

endmodule

@@ rtl/radix_digit_converter.sv @@
// radix_digit_converter
// Converts one unsigned 31-bit number per input word into digits of the base
// held in the radix register (2 to 9; lower values act as 2, higher as 9).
// Input channel in_valid/in_stall with number. Output channel
// out_valid/out_stall with digit and last_digit; digits come most significant
// first and last_digit marks the least significant one. A zero number gives
// no output words at all. Config channel cfg_valid/cfg_ready with radix; it
// is ready only while no conversion is running.
// Each division pass steps through the 8-bit chunks of the 32-bit work word
// (8 quotient bits a cycle), then a test state, and yields one digit. The
// digits are then popped from the digit stack one at a time, each by a
// registered memory read and then an output register load, before the next
// pop starts.
// One item is worked on at a time; in_stall stays high until the last digit
// sits in the output register, so the next number is taken while that digit
// still waits. A stalled output holds its word and pauses the stack pops.
// Reset clears the stack count, the output valid and sets the base to 2.
module radix_digit_converter
    import rdc_pkg::*;
#(
    parameter int STACK_DEPTH = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [NUMBER_W-1:0] number,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [DIGIT_W-1:0]  digit,
    output logic                last_digit,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [RADIX_W-1:0]  radix
);

    cmd_t    cmd;
    status_t status;

    rdc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .cfg_valid (cfg_valid),
        .status    (status),
        .in_stall  (in_stall),
        .cfg_ready (cfg_ready),
        .cmd       (cmd)
    );

    rdc_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .number     (number),
        .radix      (radix),
        .out_stall  (out_stall),
        .status     (status),
        .out_valid  (out_valid),
        .digit      (digit),
        .last_digit (last_digit)
    );

endmodule

@@ rtl/rdc_checker.sv @@
`include "assert_macros.svh"

module rdc_checker
    import rdc_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic [NUMBER_W-1:0] number,
    input logic                out_valid,
    input logic                out_stall,
    input logic [DIGIT_W-1:0]  digit,
    input logic                last_digit,
    input logic                cfg_valid,
    input logic                cfg_ready,
    input logic [RADIX_W-1:0]  radix
);

    // a stalled output word stays put
    `ASSERT_CLK(a_out_hold, (out_valid && out_stall) |=> (out_valid && $stable(digit) && $stable(last_digit)), "output word changed while stalled")

    // digits never reach the largest base
    `ASSERT_NEVER(a_digit_range, out_valid && (digit > RADIX_MAX - 4'd1), "digit out of range")

    // a taken number keeps the input side busy for at least the next cycle
    `ASSERT_CLK(a_busy_after_take, (in_valid && !in_stall) |=> in_stall, "input taken twice in a row")

    // config is taken only while no conversion runs
    `ASSERT_CLK(a_cfg_idle, cfg_ready == !in_stall, "config ready while busy")

endmodule

bind radix_digit_converter rdc_checker u_rdc_checker (.*);
